@@ src/lsi_pkg.sv @@
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared widths, register codes, reset values, control word layout and the
// microprogram of the loiter setpoint integrator.
// ----------------------------------------------------------------------------
package lsi_pkg;

    // field widths
    localparam int STICK_W    = 16;
    localparam int EST_W      = 32;
    localparam int BAND_W     = 15;
    localparam int SPEED_W    = 21;
    localparam int TICK_W     = 17;
    localparam int SP_W       = 32;
    localparam int RATE_W     = 24;
    localparam int OPA_W      = 24;
    localparam int OPB_W      = 22;
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int LEASH_CW   = EST_W + 2;
    localparam int TX_W       = 19;
    localparam int TY_W       = 18;
    localparam int TZ_W       = 18;
    localparam int FF_W       = 32;

    localparam int STICK_FRAC    = 15;
    localparam int FRAC_BITS_DEF = 16;

    // throttle counts as low below -0.1
    localparam logic signed [STICK_W-1:0] THR_LOW = -16'sd3277;

    // stream widths
    localparam int IN_BITS      = 4 * STICK_W + 1 + 4 * EST_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = TX_W + TY_W + TZ_W + SP_W + 4 * FF_W;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_BAND   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_XY      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_Z       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_TURN    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TICK_PERIOD = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LEASH       = 3'd5;

    localparam logic [BAND_W-1:0]  RST_DEAD_BAND   = 15'd3277;
    localparam logic [SPEED_W-1:0] RST_MAX_XY      = 21'd65536;
    localparam logic [SPEED_W-1:0] RST_MAX_Z       = 21'd65536;
    localparam logic [SPEED_W-1:0] RST_MAX_TURN    = 21'd131072;
    localparam logic [TICK_W-1:0]  RST_TICK_PERIOD = 17'd328;
    localparam logic [SPEED_W-1:0] RST_LEASH       = 21'd32768;

    typedef struct packed {
        logic [BAND_W-1:0]  dead_band;
        logic [SPEED_W-1:0] max_xy_speed;
        logic [SPEED_W-1:0] max_z_speed;
        logic [SPEED_W-1:0] max_turn_rate;
        logic [TICK_W-1:0]  tick_period;
        logic [SPEED_W-1:0] leash_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [STICK_W-1:0] roll_cmd;
        logic signed [STICK_W-1:0] pitch_cmd;
        logic signed [STICK_W-1:0] yaw_cmd;
        logic signed [STICK_W-1:0] throttle_stick;
        logic                      altitude_hold_mode;
        logic signed [EST_W-1:0]   est_x;
        logic signed [EST_W-1:0]   est_y;
        logic signed [EST_W-1:0]   est_z;
        logic signed [EST_W-1:0]   est_heading;
    } in_item_t;

    typedef struct packed {
        logic signed [TX_W-1:0] target_x;
        logic signed [TY_W-1:0] target_y;
        logic signed [TZ_W-1:0] target_z;
        logic signed [SP_W-1:0] target_heading;
        logic signed [FF_W-1:0] x_rate_ff;
        logic signed [FF_W-1:0] y_rate_ff;
        logic signed [FF_W-1:0] z_rate_ff;
        logic signed [FF_W-1:0] heading_rate_ff;
    } out_item_t;

    // microcode
    localparam int STEP_W = 4;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2,
        AX_H = 2'd3
    } axis_t;

    typedef enum logic [1:0] {
        MUL_NONE  = 2'd0,
        MUL_STICK = 2'd1,
        MUL_TICK  = 2'd2
    } mul_op_t;

    typedef enum logic [1:0] {
        WB_NONE  = 2'd0,
        WB_RATE  = 2'd1,
        WB_SETPT = 2'd2
    } wb_op_t;

    typedef enum logic [1:0] {
        CND_NEVER    = 2'd0,
        CND_NO_INPUT = 2'd1,
        CND_OUT_BUSY = 2'd2
    } cond_t;

    typedef struct packed {
        mul_op_t           mul_op;
        axis_t             mul_axis;
        wb_op_t            wb_op;
        axis_t             wb_axis;
        logic              take_in;
        logic              emit;
        cond_t             cond;
        logic [STEP_W-1:0] jmp_addr;
        logic [STEP_W-1:0] next_addr;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } seq_status_t;

    localparam logic [STEP_W-1:0] ST_WAIT = 4'd0;
    localparam logic [STEP_W-1:0] ST_EMIT = 4'd10;

    // at most one multiply per step; rate and setpoint writebacks overlap the next multiply
    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] addr);
        ctrl_word_t cw;
        cw = '{mul_op: MUL_NONE, mul_axis: AX_X, wb_op: WB_NONE, wb_axis: AX_X,
               take_in: 1'b0, emit: 1'b0, cond: CND_NEVER,
               jmp_addr: ST_WAIT, next_addr: ST_WAIT};
        case (addr)
            4'd0: begin
                cw.take_in = 1'b1; cw.cond = CND_NO_INPUT;
                cw.jmp_addr = 4'd0; cw.next_addr = 4'd1;
            end
            4'd1: begin
                cw.mul_op = MUL_STICK; cw.mul_axis = AX_X; cw.next_addr = 4'd2;
            end
            4'd2: begin
                cw.mul_op = MUL_STICK; cw.mul_axis = AX_Y;
                cw.wb_op = WB_RATE; cw.wb_axis = AX_X; cw.next_addr = 4'd3;
            end
            4'd3: begin
                cw.mul_op = MUL_TICK; cw.mul_axis = AX_X;
                cw.wb_op = WB_RATE; cw.wb_axis = AX_Y; cw.next_addr = 4'd4;
            end
            4'd4: begin
                cw.mul_op = MUL_STICK; cw.mul_axis = AX_Z;
                cw.wb_op = WB_SETPT; cw.wb_axis = AX_X; cw.next_addr = 4'd5;
            end
            4'd5: begin
                cw.mul_op = MUL_TICK; cw.mul_axis = AX_Y;
                cw.wb_op = WB_RATE; cw.wb_axis = AX_Z; cw.next_addr = 4'd6;
            end
            4'd6: begin
                cw.mul_op = MUL_STICK; cw.mul_axis = AX_H;
                cw.wb_op = WB_SETPT; cw.wb_axis = AX_Y; cw.next_addr = 4'd7;
            end
            4'd7: begin
                cw.mul_op = MUL_TICK; cw.mul_axis = AX_Z;
                cw.wb_op = WB_RATE; cw.wb_axis = AX_H; cw.next_addr = 4'd8;
            end
            4'd8: begin
                cw.mul_op = MUL_TICK; cw.mul_axis = AX_H;
                cw.wb_op = WB_SETPT; cw.wb_axis = AX_Z; cw.next_addr = 4'd9;
            end
            4'd9: begin
                cw.wb_op = WB_SETPT; cw.wb_axis = AX_H; cw.next_addr = ST_EMIT;
            end
            4'd10: begin
                cw.emit = 1'b1; cw.cond = CND_OUT_BUSY;
                cw.jmp_addr = ST_EMIT; cw.next_addr = ST_WAIT;
            end
            default: begin
                cw.next_addr = ST_WAIT;
            end
        endcase
        return cw;
    endfunction

endpackage

@@ src/lsi_sequencer.sv @@
// ----------------------------------------------------------------------------
// lsi_sequencer
// Step counter over the microprogram ROM with conditional jumps.
// ----------------------------------------------------------------------------
module lsi_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lsi_pkg::seq_status_t status,
    output lsi_pkg::ctrl_word_t  ctrl
);

    logic [lsi_pkg::STEP_W-1:0] step_reg;
    logic [lsi_pkg::STEP_W-1:0] step_next;
    logic                       take_jump;

    assign ctrl = lsi_pkg::ucode(step_reg);

    always_comb begin
        case (ctrl.cond)
            lsi_pkg::CND_NO_INPUT: take_jump = !status.in_valid;
            lsi_pkg::CND_OUT_BUSY: take_jump = status.out_busy;
            default:               take_jump = 1'b0;
        endcase
        step_next = take_jump ? ctrl.jmp_addr : ctrl.next_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= lsi_pkg::ST_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

@@ src/lsi_datapath.sv @@
// ----------------------------------------------------------------------------
// lsi_datapath
// Input holding register, shared multiplier, rounding, leash check and setpoint
// integration (saturating on x, y, z, wrapping on heading), steered by the control word.
// ----------------------------------------------------------------------------
module lsi_datapath #(
    parameter int FRAC_BITS = lsi_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lsi_pkg::cfg_t       cfg,
    input  logic                load_in,
    input  lsi_pkg::in_item_t   in_item,
    input  lsi_pkg::ctrl_word_t ctrl,
    output lsi_pkg::out_item_t  result
);

    localparam int PW = lsi_pkg::PROD_W;
    localparam int SW = lsi_pkg::SUM_W;
    localparam int LW = lsi_pkg::LEASH_CW;

    localparam logic signed [PW-1:0] HALF_STICK = PW'(1) << (lsi_pkg::STICK_FRAC - 1);
    localparam logic signed [PW-1:0] HALF_FRAC  = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] ONE        = SW'(1) << FRAC_BITS;
    localparam logic signed [SW-1:0] TWO        = SW'(2) << FRAC_BITS;

    lsi_pkg::in_item_t in_reg;

    logic signed [PW-1:0]                 prod_reg;
    logic signed [lsi_pkg::RATE_W-1:0]    rate_reg [4];
    logic signed [lsi_pkg::SP_W-1:0]      sp_reg   [4];

    // stick conditioning
    logic signed [16:0] pitch_s, pitch_abs, pitch_db;
    logic signed [16:0] roll_s, roll_abs, roll_db;
    logic signed [16:0] band_s;
    logic signed [17:0] full_raw, full_sat, full_abs, full_db, band2_s;
    logic               heading_hold;

    // shared multiplier operands
    logic signed [lsi_pkg::OPA_W-1:0] opa;
    logic signed [lsi_pkg::OPB_W-1:0] opb;
    logic signed [PW-1:0]             mul_res;

    // writeback
    logic signed [PW-1:0]              sum_stick, sum_frac, r15_full, delta;
    logic signed [lsi_pkg::RATE_W-1:0] rate_new, rate_wb;
    logic signed [lsi_pkg::SP_W-1:0]   sp_sel;
    logic signed [lsi_pkg::EST_W-1:0]  est_sel;
    logic signed [LW-1:0]              sp_wide, lead_hi, lead_lo, lim_wide;
    logic signed [SW-1:0]              sp_sum, box_lo, box_hi, sp_clamped;
    logic signed [lsi_pkg::SP_W-1:0]   sp_wb;

    always_comb begin
        band_s    = $signed({2'b00, cfg.dead_band});
        band2_s   = $signed({2'b00, cfg.dead_band, 1'b0});

        pitch_s   = {in_reg.pitch_cmd[15], in_reg.pitch_cmd};
        pitch_abs = (pitch_s < 0) ? -pitch_s : pitch_s;
        pitch_db  = (pitch_abs < band_s) ? '0 : pitch_s;

        roll_s    = {in_reg.roll_cmd[15], in_reg.roll_cmd};
        roll_abs  = (roll_s < 0) ? -roll_s : roll_s;
        roll_db   = (roll_abs < band_s) ? '0 : roll_s;

        // 2*t - 1 saturated to plus or minus one in Q3.15
        full_raw = ($signed({{2{in_reg.throttle_stick[15]}}, in_reg.throttle_stick}) <<< 1)
                   - 18'sd32768;
        if (full_raw < -18'sd32768) begin
            full_sat = -18'sd32768;
        end else if (full_raw > 18'sd32768) begin
            full_sat = 18'sd32768;
        end else begin
            full_sat = full_raw;
        end
        full_abs = (full_sat < 0) ? -full_sat : full_sat;
        full_db  = (full_abs < band2_s) ? '0 : full_sat;

        heading_hold = (in_reg.throttle_stick < lsi_pkg::THR_LOW)
                       && !in_reg.altitude_hold_mode;
    end

    always_comb begin
        opa = '0;
        opb = '0;
        case (ctrl.mul_op)
            lsi_pkg::MUL_STICK: begin
                case (ctrl.mul_axis)
                    lsi_pkg::AX_X: begin
                        opa = -lsi_pkg::OPA_W'(pitch_db);
                        opb = $signed(lsi_pkg::OPB_W'(cfg.max_xy_speed));
                    end
                    lsi_pkg::AX_Y: begin
                        opa = lsi_pkg::OPA_W'(roll_db);
                        opb = $signed(lsi_pkg::OPB_W'(cfg.max_xy_speed));
                    end
                    lsi_pkg::AX_Z: begin
                        opa = -lsi_pkg::OPA_W'(full_db);
                        opb = $signed(lsi_pkg::OPB_W'(cfg.max_z_speed));
                    end
                    default: begin
                        opa = lsi_pkg::OPA_W'(in_reg.yaw_cmd);
                        opb = $signed(lsi_pkg::OPB_W'(cfg.max_turn_rate));
                    end
                endcase
            end
            lsi_pkg::MUL_TICK: begin
                opa = rate_reg[ctrl.mul_axis];
                opb = $signed(lsi_pkg::OPB_W'(cfg.tick_period));
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
        mul_res = opa * opb;
    end

    always_comb begin
        // round half up, then floor shift
        sum_stick = prod_reg + HALF_STICK;
        r15_full  = sum_stick >>> lsi_pkg::STICK_FRAC;
        rate_new  = r15_full[lsi_pkg::RATE_W-1:0];
        sum_frac  = prod_reg + HALF_FRAC;
        delta     = sum_frac >>> FRAC_BITS;

        sp_sel = sp_reg[ctrl.wb_axis];
        case (ctrl.wb_axis)
            lsi_pkg::AX_X: est_sel = in_reg.est_x;
            lsi_pkg::AX_Y: est_sel = in_reg.est_y;
            lsi_pkg::AX_Z: est_sel = in_reg.est_z;
            default:       est_sel = in_reg.est_heading;
        endcase

        // leash on x, y and z: no rate that pushes the setpoint further past estimate +- limit
        lim_wide = $signed(LW'(cfg.leash_limit));
        sp_wide  = LW'(sp_sel);
        lead_hi  = LW'(est_sel) + lim_wide;
        lead_lo  = LW'(est_sel) - lim_wide;
        rate_wb  = rate_new;
        if (ctrl.wb_axis == lsi_pkg::AX_H) begin
            if (heading_hold) begin
                rate_wb = '0;
            end
        end else if (sp_wide > lead_hi) begin
            if (rate_new > 0) begin
                rate_wb = '0;
            end
        end else if (sp_wide < lead_lo) begin
            if (rate_new < 0) begin
                rate_wb = '0;
            end
        end

        case (ctrl.wb_axis)
            lsi_pkg::AX_X: begin box_lo = -TWO; box_hi = TWO; end
            lsi_pkg::AX_Y: begin box_lo = -ONE; box_hi = ONE; end
            default:       begin box_lo = -TWO; box_hi = '0;  end
        endcase
        sp_sum = SW'(sp_sel) + SW'(delta);
        if (sp_sum < box_lo) begin
            sp_clamped = box_lo;
        end else if (sp_sum > box_hi) begin
            sp_clamped = box_hi;
        end else begin
            sp_clamped = sp_sum;
        end

        if (ctrl.wb_axis == lsi_pkg::AX_H) begin
            sp_wb = heading_hold ? in_reg.est_heading
                                 : sp_sel + delta[lsi_pkg::SP_W-1:0];
        end else begin
            sp_wb = sp_clamped[lsi_pkg::SP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            in_reg <= in_item;
        end
        if (ctrl.mul_op != lsi_pkg::MUL_NONE) begin
            prod_reg <= mul_res;
        end
        if (ctrl.wb_op == lsi_pkg::WB_RATE) begin
            rate_reg[ctrl.wb_axis] <= rate_wb;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                sp_reg[i] <= '0;
            end
        end else if (ctrl.wb_op == lsi_pkg::WB_SETPT) begin
            sp_reg[ctrl.wb_axis] <= sp_wb;
        end
    end

    always_comb begin
        result.target_x        = sp_reg[lsi_pkg::AX_X][lsi_pkg::TX_W-1:0];
        result.target_y        = sp_reg[lsi_pkg::AX_Y][lsi_pkg::TY_W-1:0];
        result.target_z        = sp_reg[lsi_pkg::AX_Z][lsi_pkg::TZ_W-1:0];
        result.target_heading  = sp_reg[lsi_pkg::AX_H];
        result.x_rate_ff       = lsi_pkg::FF_W'(rate_reg[lsi_pkg::AX_X]);
        result.y_rate_ff       = lsi_pkg::FF_W'(rate_reg[lsi_pkg::AX_Y]);
        result.z_rate_ff       = lsi_pkg::FF_W'(rate_reg[lsi_pkg::AX_Z]);
        result.heading_rate_ff = lsi_pkg::FF_W'(rate_reg[lsi_pkg::AX_H]);
    end

endmodule

@@ src/loiter_setpoint_integrator_core.sv @@
// ----------------------------------------------------------------------------
// loiter_setpoint_integrator_core
// Stick-rate setpoint integrator with leash for loiter flight.
//
//   channel  dir  handshake              content
//   s_       in   s_tvalid / s_tready    sticks, mode flag, estimates
//   m_       out  m_tvalid / m_tready    setpoints and rate feed-forwards
//   cfg_     in   cfg_valid / cfg_ready  register index and write data
//
// A word is taken in the wait step; its result loads the output register in
// the emit step, after nine steps in which eight multiplies share one 24x22
// multiplier, and the next word can be taken only in the wait step after it.
// Reset is synchronous on aresetn; setpoints clear and registers take defaults.
// A stalled result sits in the output register; the sequencer holds in its
// emit step only if that register is still full when the next result is ready.
// ----------------------------------------------------------------------------
module loiter_setpoint_integrator_core #(
    parameter int FRAC_BITS = lsi_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // roll, pitch, yaw, throttle sticks, altitude_hold_mode,
    // est_x, est_y, est_z, est_heading (lowest bit first)
    input  logic [lsi_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // target_x, target_y, target_z, target_heading, x_rate_ff, y_rate_ff,
    // z_rate_ff, heading_rate_ff (lowest bit first)
    output logic [lsi_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lsi_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lsi_pkg::CFG_DATA_W-1:0]     cfg_data
);

    lsi_pkg::cfg_t        cfg_reg;
    lsi_pkg::ctrl_word_t  ctrl;
    lsi_pkg::seq_status_t status;
    lsi_pkg::in_item_t    in_item;
    lsi_pkg::out_item_t   result;

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [lsi_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic                            in_fire, out_busy, out_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dead_band     <= lsi_pkg::RST_DEAD_BAND;
            cfg_reg.max_xy_speed  <= lsi_pkg::RST_MAX_XY;
            cfg_reg.max_z_speed   <= lsi_pkg::RST_MAX_Z;
            cfg_reg.max_turn_rate <= lsi_pkg::RST_MAX_TURN;
            cfg_reg.tick_period   <= lsi_pkg::RST_TICK_PERIOD;
            cfg_reg.leash_limit   <= lsi_pkg::RST_LEASH;
        end else if (cfg_valid) begin
            case (cfg_addr)
                lsi_pkg::REG_DEAD_BAND:   cfg_reg.dead_band     <= cfg_data[lsi_pkg::BAND_W-1:0];
                lsi_pkg::REG_MAX_XY:      cfg_reg.max_xy_speed  <= cfg_data;
                lsi_pkg::REG_MAX_Z:       cfg_reg.max_z_speed   <= cfg_data;
                lsi_pkg::REG_MAX_TURN:    cfg_reg.max_turn_rate <= cfg_data;
                lsi_pkg::REG_TICK_PERIOD: cfg_reg.tick_period   <= cfg_data[lsi_pkg::TICK_W-1:0];
                lsi_pkg::REG_LEASH:       cfg_reg.leash_limit   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_item.roll_cmd           = s_tdata[15:0];
        in_item.pitch_cmd          = s_tdata[31:16];
        in_item.yaw_cmd            = s_tdata[47:32];
        in_item.throttle_stick     = s_tdata[63:48];
        in_item.altitude_hold_mode = s_tdata[64];
        in_item.est_x              = s_tdata[96:65];
        in_item.est_y              = s_tdata[128:97];
        in_item.est_z              = s_tdata[160:129];
        in_item.est_heading        = s_tdata[192:161];
    end

    assign s_tready        = ctrl.take_in;
    assign in_fire         = s_tvalid && ctrl.take_in;
    assign out_busy        = m_tvalid_reg && !m_tready;
    assign out_load        = ctrl.emit && !out_busy;
    assign status.in_valid = s_tvalid;
    assign status.out_busy = out_busy;

    lsi_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    lsi_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .load_in (in_fire),
        .in_item (in_item),
        .ctrl    (ctrl),
        .result  (result)
    );

    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {1'b0, result.heading_rate_ff, result.z_rate_ff, result.y_rate_ff,
                            result.x_rate_ff, result.target_heading, result.target_z,
                            result.target_y, result.target_x};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ dv/loiter_setpoint_integrator_core_test.sv @@
// ----------------------------------------------------------------------------
// loiter_setpoint_integrator_core_test
// Self-checking bench for the loiter setpoint integrator. A directed table
// covers stick extremes, dead band and low throttle edges, the leash in both
// directions, a frozen tick period, ignored register indexes and saturation
// and wrap of the setpoints. Random phases with changing register settings
// follow, and every result word is checked field by field against a local
// model of the setpoint integration or a value written in the table.
// ----------------------------------------------------------------------------
module loiter_setpoint_integrator_core_test;
    import lsi_pkg::*;

    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int LATENCY      = 11;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 280;
    localparam int STALL_CYCLES = 300;
    localparam longint STICK_ONE = 32768;
    localparam longint POS_ONE   = longint'(1) << FRAC;

    // indexes past the register file, writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

    typedef enum logic {
        ROW_WORD = 1'b0,
        ROW_REG  = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_ADDR_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        in_item_t                word;
        logic                    typed;
        out_item_t               want;
    } row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    loiter_setpoint_integrator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // register copy and integrator state of the local model
    logic [BAND_W-1:0]  band_q;
    logic [SPEED_W-1:0] xy_speed_q;
    logic [SPEED_W-1:0] z_speed_q;
    logic [SPEED_W-1:0] turn_rate_q;
    logic [TICK_W-1:0]  tick_q;
    logic [SPEED_W-1:0] leash_q;
    longint             sp_x;
    longint             sp_y;
    longint             sp_z;
    logic signed [31:0] sp_h;

    logic [OUT_TDATA_W-1:0] expected_words[$];
    row_t                   stimulus_table[$];

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    int stall_left    = 0;
    bit stall_request = 1'b0;
    bit stall_taken   = 1'b0;

    // round to nearest, ties up
    function automatic longint round_div(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint band_pass(longint s, longint band);
        longint mag;
        mag = (s < 0) ? -s : s;
        return (mag < band) ? 0 : s;
    endfunction

    function automatic longint leash_clamp(longint sp, longint est, longint rate);
        longint lim;
        lim = longint'(leash_q);
        if (sp > est + lim) begin
            if (rate > 0) rate = 0;
        end else if (sp < est - lim) begin
            if (rate < 0) rate = 0;
        end
        return rate;
    endfunction

    function automatic longint step_axis(longint sp, longint rate, longint lo, longint hi);
        sp = sp + round_div(rate * longint'(tick_q), FRAC);
        if (sp < lo) sp = lo;
        if (sp > hi) sp = hi;
        return sp;
    endfunction

    function automatic out_item_t predict_setpoints(in_item_t w);
        longint roll, pitch, yaw, thr, band, full, delta;
        longint xr, yr, zr, hr;
        out_item_t o;
        roll  = longint'($signed(w.roll_cmd));
        pitch = longint'($signed(w.pitch_cmd));
        yaw   = longint'($signed(w.yaw_cmd));
        thr   = longint'($signed(w.throttle_stick));
        band  = longint'(band_q);

        xr = round_div(-band_pass(pitch, band) * longint'(xy_speed_q), STICK_FRAC);
        yr = round_div(band_pass(roll, band) * longint'(xy_speed_q), STICK_FRAC);
        xr = leash_clamp(sp_x, longint'($signed(w.est_x)), xr);
        sp_x = step_axis(sp_x, xr, -2 * POS_ONE, 2 * POS_ONE);
        yr = leash_clamp(sp_y, longint'($signed(w.est_y)), yr);
        sp_y = step_axis(sp_y, yr, -POS_ONE, POS_ONE);

        // throttle maps to 2*t-1, saturated to full deflection
        full = 2 * thr - STICK_ONE;
        if (full < -STICK_ONE) full = -STICK_ONE;
        if (full > STICK_ONE) full = STICK_ONE;
        zr = round_div(-band_pass(full, 2 * band) * longint'(z_speed_q), STICK_FRAC);
        zr = leash_clamp(sp_z, longint'($signed(w.est_z)), zr);
        sp_z = step_axis(sp_z, zr, -2 * POS_ONE, 0);

        if (thr < longint'(THR_LOW) && !w.altitude_hold_mode) begin
            sp_h = w.est_heading;
            hr = 0;
        end else begin
            hr = round_div(yaw * longint'(turn_rate_q), STICK_FRAC);
            delta = round_div(hr * longint'(tick_q), FRAC);
            sp_h = sp_h + delta[31:0];
        end

        o.target_x        = sp_x[TX_W-1:0];
        o.target_y        = sp_y[TY_W-1:0];
        o.target_z        = sp_z[TZ_W-1:0];
        o.target_heading  = sp_h;
        o.x_rate_ff       = xr[FF_W-1:0];
        o.y_rate_ff       = yr[FF_W-1:0];
        o.z_rate_ff       = zr[FF_W-1:0];
        o.heading_rate_ff = hr[FF_W-1:0];
        return o;
    endfunction

    function automatic void apply_register(logic [CFG_ADDR_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_DEAD_BAND:   band_q      = val[BAND_W-1:0];
            REG_MAX_XY:      xy_speed_q  = val[SPEED_W-1:0];
            REG_MAX_Z:       z_speed_q   = val[SPEED_W-1:0];
            REG_MAX_TURN:    turn_rate_q = val[SPEED_W-1:0];
            REG_TICK_PERIOD: tick_q      = val[TICK_W-1:0];
            REG_LEASH:       leash_q     = val[SPEED_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_word(in_item_t w);
        return {7'd0, w.est_heading, w.est_z, w.est_y, w.est_x, w.altitude_hold_mode,
                w.throttle_stick, w.yaw_cmd, w.pitch_cmd, w.roll_cmd};
    endfunction

    function automatic logic [OUT_TDATA_W-1:0] pack_result(out_item_t o);
        return {1'b0, o.heading_rate_ff, o.z_rate_ff, o.y_rate_ff, o.x_rate_ff,
                o.target_heading, o.target_z, o.target_y, o.target_x};
    endfunction

    function automatic logic [31:0] result_field(logic [OUT_TDATA_W-1:0] w, int f);
        case (f)
            0:       return {13'd0, w[18:0]};
            1:       return {14'd0, w[36:19]};
            2:       return {14'd0, w[54:37]};
            3:       return w[86:55];
            4:       return w[118:87];
            5:       return w[150:119];
            6:       return w[182:151];
            default: return w[214:183];
        endcase
    endfunction

    function automatic string field_name(int f);
        case (f)
            0:       return "target_x";
            1:       return "target_y";
            2:       return "target_z";
            3:       return "target_heading";
            4:       return "x_rate_ff";
            5:       return "y_rate_ff";
            6:       return "z_rate_ff";
            default: return "heading_rate_ff";
        endcase
    endfunction

    function automatic in_item_t make_word(logic [15:0] roll, logic [15:0] pitch,
                                           logic [15:0] yaw, logic [15:0] thr, logic alt,
                                           logic [31:0] ex, logic [31:0] ey,
                                           logic [31:0] ez, logic [31:0] eh);
        in_item_t w;
        w.roll_cmd           = roll;
        w.pitch_cmd          = pitch;
        w.yaw_cmd            = yaw;
        w.throttle_stick     = thr;
        w.altitude_hold_mode = alt;
        w.est_x              = ex;
        w.est_y              = ey;
        w.est_z              = ez;
        w.est_heading        = eh;
        return w;
    endfunction

    function automatic row_t word_row(in_item_t w);
        row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.word = w;
        return r;
    endfunction

    function automatic row_t reg_row(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        row_t r;
        r = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic logic [15:0] pick_stick(int band);
        int v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 1) ? 32767 : -32768;
            1: begin
                // just under, on and just over the dead band
                v = band - 1 + int'($urandom_range(0, 2));
                if ($urandom_range(0, 1)) v = -v;
            end
            2: v = 0;
            default: v = int'($urandom_range(0, 65535));
        endcase
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_throttle(int band);
        int v;
        case ($urandom_range(0, 11))
            0: v = $urandom_range(0, 1) ? 32767 : -32768;
            1: v = -3278 + int'($urandom_range(0, 2));
            2: begin
                // 2*t-1 lands around twice the dead band
                v = band - 1 + int'($urandom_range(0, 1));
                v = $urandom_range(0, 1) ? 16384 + v : 16384 - v;
            end
            3: v = 16384;
            default: v = int'($urandom_range(0, 65535));
        endcase
        return v[15:0];
    endfunction

    // estimates mostly sit within a couple of leash lengths of the setpoint
    function automatic logic [31:0] near_estimate(longint sp);
        longint lim, off, v;
        lim = longint'(leash_q);
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: begin
                off = lim - 1 + longint'($urandom_range(0, 2));
                if ($urandom_range(0, 1)) off = -off;
            end
            default: off = longint'($urandom_range(0, 32'(2 * lim + 32))) - (lim + 16);
        endcase
        v = sp + off;
        return v[31:0];
    endfunction

    function automatic in_item_t random_word();
        in_item_t w;
        int band;
        band = int'(band_q);
        w.roll_cmd           = pick_stick(band);
        w.pitch_cmd          = pick_stick(band);
        w.yaw_cmd            = ($urandom_range(0, 7) == 0) ?
                               ($urandom_range(0, 1) ? 16'h7fff : 16'h8000) :
                               16'($urandom_range(0, 65535));
        w.throttle_stick     = pick_throttle(band);
        w.altitude_hold_mode = 1'($urandom_range(0, 1));
        w.est_x              = near_estimate(sp_x);
        w.est_y              = near_estimate(sp_y);
        w.est_z              = near_estimate(sp_z);
        w.est_heading        = $urandom();
        return w;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(logic [CFG_ADDR_W-1:0] idx);
        logic [CFG_DATA_W-1:0] lo, hi, mid;
        int r;
        case (idx)
            REG_DEAD_BAND: begin
                lo = 0; hi = 32767; mid = CFG_DATA_W'($urandom_range(0, 8000));
            end
            REG_TICK_PERIOD: begin
                lo = 1; hi = 65536; mid = CFG_DATA_W'($urandom_range(1, 8192));
            end
            REG_LEASH: begin
                lo = 0; hi = 1048576; mid = CFG_DATA_W'($urandom_range(0, 200000));
            end
            default: begin
                lo = 0; hi = 1048576; mid = CFG_DATA_W'($urandom_range(0, 300000));
            end
        endcase
        r = $urandom_range(0, 5);
        return (r == 0) ? lo : (r == 1) ? hi : mid;
    endfunction

    task automatic send_word(input in_item_t w, input logic typed, input out_item_t want);
        out_item_t got;
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = pack_word(w);
        s_tvalid = 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        got = predict_setpoints(w);
        expected_words.push_back(pack_result(typed ? want : got));
    endtask

    // only between words, once every pending result is out
    task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_words.size() != 0) @(negedge aclk);
        cfg_addr  = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        apply_register(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure_phase();
        write_register(REG_DEAD_BAND, pick_reg_value(REG_DEAD_BAND));
        write_register(REG_MAX_XY, pick_reg_value(REG_MAX_XY));
        write_register(REG_MAX_Z, pick_reg_value(REG_MAX_Z));
        write_register(REG_MAX_TURN, pick_reg_value(REG_MAX_TURN));
        write_register(REG_TICK_PERIOD, pick_reg_value(REG_TICK_PERIOD));
        write_register(REG_LEASH, pick_reg_value(REG_LEASH));
        if ($urandom_range(0, 1))
            write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                           CFG_DATA_W'($urandom()));
    endtask

    task automatic build_table();
        row_t r;
        // idle sticks right after reset leave everything at zero
        r = word_row(make_word(0, 0, 0, 16384, 1'b1, 0, 0, 0, 0));
        r.typed = 1'b1;
        stimulus_table.push_back(r);
        // low throttle holds the heading, z rate at full descent, z pinned at 0
        r = word_row(make_word(0, 0, 0, -32768, 1'b0, 0, 0, 0, 32'h7fff_ffff));
        r.typed = 1'b1;
        r.want.target_heading = 32'h7fff_ffff;
        r.want.z_rate_ff      = 32'd65536;
        stimulus_table.push_back(r);
        // dead band edges, twice the band on the throttle
        stimulus_table.push_back(word_row(make_word(3276, 3277, 0, 19660, 1'b0,
                                                    0, 0, 0, 0)));
        stimulus_table.push_back(word_row(make_word(-3277, -3276, 1, 19661, 1'b0,
                                                    0, 0, 0, 0)));
        // low throttle threshold with and without altitude hold
        stimulus_table.push_back(word_row(make_word(0, 0, 100, -3277, 1'b0, 0, 0, 0, 5)));
        stimulus_table.push_back(word_row(make_word(0, 0, 100, -3278, 1'b1, 0, 0, 0, 5)));
        stimulus_table.push_back(word_row(make_word(0, 0, 100, -3278, 1'b0, 0, 0, 0, -5)));
        // leash on both sides of the estimate
        stimulus_table.push_back(word_row(make_word(32767, 32767, 0, 16384, 1'b1,
                                                    100000, -100000, 0, 0)));
        stimulus_table.push_back(word_row(make_word(-32768, -32768, 0, 32767, 1'b1,
                                                    -100000, 100000, -100000, 0)));
        // zero tick period freezes integration
        stimulus_table.push_back(reg_row(REG_TICK_PERIOD, 0));
        stimulus_table.push_back(word_row(make_word(32767, -32768, 32767, 32767, 1'b1,
                                                    0, 0, 0, 0)));
        stimulus_table.push_back(reg_row(REG_SPARE_A, 21'h1fffff));
        stimulus_table.push_back(reg_row(REG_SPARE_B, 21'h0aaaaa));
        stimulus_table.push_back(word_row(make_word(32767, -32768, 32767, 32767, 1'b1,
                                                    0, 0, 0, 0)));
        // top of every range, setpoints saturate in one tick
        stimulus_table.push_back(reg_row(REG_TICK_PERIOD, 65536));
        stimulus_table.push_back(reg_row(REG_MAX_XY, 1048576));
        stimulus_table.push_back(reg_row(REG_MAX_Z, 1048576));
        stimulus_table.push_back(reg_row(REG_MAX_TURN, 1048576));
        stimulus_table.push_back(reg_row(REG_LEASH, 1048576));
        stimulus_table.push_back(reg_row(REG_DEAD_BAND, 0));
        stimulus_table.push_back(word_row(make_word(32767, -32768, 32767, 0, 1'b1,
                                                    0, 0, 0, 0)));
        stimulus_table.push_back(word_row(make_word(-32768, 32767, -32768, 32767, 1'b0,
                                                    0, 0, 0, 0)));
        // hold at the heading maximum, then integrate past it
        stimulus_table.push_back(word_row(make_word(0, 0, 0, -32768, 1'b0,
                                                    0, 0, 0, 32'h7fff_ffff)));
        stimulus_table.push_back(word_row(make_word(0, 0, 32767, 16384, 1'b1, 0, 0, 0, 0)));
        stimulus_table.push_back(reg_row(REG_DEAD_BAND, 32767));
        stimulus_table.push_back(word_row(make_word(32767, -32767, 0, 32767, 1'b0,
                                                    0, 0, 0, 0)));
        // bottom of every range
        stimulus_table.push_back(reg_row(REG_MAX_XY, 0));
        stimulus_table.push_back(reg_row(REG_MAX_Z, 0));
        stimulus_table.push_back(reg_row(REG_MAX_TURN, 0));
        stimulus_table.push_back(reg_row(REG_LEASH, 0));
        stimulus_table.push_back(reg_row(REG_TICK_PERIOD, 1));
        stimulus_table.push_back(word_row(make_word(32767, -32768, 32767, 0, 1'b1,
                                                    5, -5, 0, 0)));
    endtask

    // receiver side, with one long hold-off to back the block up
    always @(negedge aclk) begin
        if (stall_request && !stall_taken) begin
            stall_taken = 1'b1;
            stall_left  = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            m_tready   = 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        logic [OUT_TDATA_W-1:0] want;
        logic [31:0] e;
        logic [31:0] a;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: result word %h with nothing expected", $time, m_tdata);
                mismatches = mismatches + 1;
            end else begin
                want = expected_words.pop_front();
                for (int f = 0; f < 8; f++) begin
                    e = result_field(want, f);
                    a = result_field(m_tdata, f);
                    if (a !== e) begin
                        $display("%0t: %s expected %h actual %h", $time, field_name(f), e, a);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count = cycle_count + 1;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : run
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        band_q      = RST_DEAD_BAND;
        xy_speed_q  = RST_MAX_XY;
        z_speed_q   = RST_MAX_Z;
        turn_rate_q = RST_MAX_TURN;
        tick_q      = RST_TICK_PERIOD;
        leash_q     = RST_LEASH;
        sp_x = 0;
        sp_y = 0;
        sp_z = 0;
        sp_h = '0;

        tx_idle_pct = 28;
        rx_idle_pct = 49;
        build_table();
        foreach (stimulus_table[i]) begin
            if (stimulus_table[i].kind == ROW_REG)
                write_register(stimulus_table[i].reg_idx, stimulus_table[i].reg_val);
            else
                send_word(stimulus_table[i].word, stimulus_table[i].typed,
                          stimulus_table[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase / 2)
                0:       begin tx_idle_pct = 28; rx_idle_pct = 49; end
                1:       begin tx_idle_pct = 49; rx_idle_pct = 28; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            configure_phase();
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (phase == 4 && n == 40) stall_request = 1'b1;
                send_word(random_word(), 1'b0, '0);
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (3 * LATENCY) @(posedge aclk);

        if (mismatches == 0 && expected_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
